>>> src/hsi_pkg.sv
// Shared types and constants for the linear-probing hash set insert core.
// No dependencies; every other file takes names from here by scope.
package hsi_pkg;

  // Key and result field widths
  localparam int KEY_W  = 64;
  localparam int SLOT_W = 10;

  // Multiplicative hash constant (golden ratio, 64 bits)
  localparam logic [KEY_W-1:0] GOLDEN_MULT = 64'h9E37_79B9_7F4A_7C15;

  // Empty-slot marker; also the one key value that is rejected
  localparam logic [KEY_W-1:0] EMPTY_KEY = '1;

  // Depth of the queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Result status codes
  typedef enum logic [1:0] {
    ST_PRESENT  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_PROBE
  } back_state_t;

endpackage

>>> src/hsi_if.sv
// Valid/ready channel interfaces for the hash set insert core.
// Depends on hsi_pkg for field widths and the status type.
interface hsi_in_if;
  logic                      valid;
  logic                      ready;
  logic [hsi_pkg::KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface hsi_out_if;
  logic                       valid;
  logic                       ready;
  hsi_pkg::status_t           status;
  logic [hsi_pkg::SLOT_W-1:0] slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

>>> src/hsi_front.sv
// Front end: accepts keys, flags the reserved key and computes the home slot.
// Depends on hsi_pkg and hsi_in_if; feeds the queue in hsi_queue.
module hsi_front #(
  parameter int TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  hsi_in_if.sink                in_ch,
  input  logic                  clearing,
  input  logic                  q_ready,
  output logic                  q_push,
  output logic [TABLE_BITS+hsi_pkg::KEY_W:0] q_data
);

  logic                        s_vld_r, s_vld_nxt;
  logic [hsi_pkg::KEY_W-1:0]   s_key_r;
  logic [TABLE_BITS-1:0]       s_home_r;
  logic                        s_rsv_r;
  logic [2*TABLE_BITS-1:0]     prod;
  logic [TABLE_BITS-1:0]       key_lo;
  logic [TABLE_BITS-1:0]       mult_lo;
  logic                        take;

  // Only the low bits of key and constant reach the low bits of the product
  assign key_lo  = in_ch.key[TABLE_BITS-1:0];
  assign mult_lo = hsi_pkg::GOLDEN_MULT[TABLE_BITS-1:0];
  assign prod    = key_lo * mult_lo;

  // Stage is free when empty or draining into the queue this cycle, and never while clearing
  assign in_ch.ready = !clearing && (!s_vld_r || q_ready);
  assign take        = in_ch.valid && in_ch.ready;

  assign q_push = s_vld_r && q_ready;
  assign q_data = {s_rsv_r, s_home_r, s_key_r};

  always_comb begin
    s_vld_nxt = s_vld_r;
    if (take) begin
      s_vld_nxt = 1'b1;
    end else if (q_push) begin
      s_vld_nxt = 1'b0;
    end
  end

  // Hold stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= s_vld_nxt;
    end
  end

  // Capture key, hash and reserved flag on each beat
  always_ff @(posedge clk) begin
    if (take) begin
      s_key_r  <= in_ch.key;
      s_home_r <= prod[TABLE_BITS-1:0];
      s_rsv_r  <= (in_ch.key == hsi_pkg::EMPTY_KEY);
    end
  end

endmodule

>>> src/hsi_queue.sv
// Short register queue that decouples the front end from the probe engine.
// Depends on hsi_pkg for its depth.
module hsi_queue #(
  parameter int WIDTH = 75
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             push_ok,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0]           entry_r [hsi_pkg::QDEPTH];
  logic [hsi_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hsi_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [hsi_pkg::QCNT_W-1:0] cnt_r, cnt_nxt;

  assign push_ok   = (cnt_r != hsi_pkg::QCNT_W'(hsi_pkg::QDEPTH));
  assign pop_valid = (cnt_r != '0);
  assign pop_data  = entry_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == hsi_pkg::QPTR_W'(hsi_pkg::QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == hsi_pkg::QPTR_W'(hsi_pkg::QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Push only with room, pop only with data
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> push_ok) else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> pop_valid) else $error("queue pop while empty");

endmodule

>>> src/hsi_back.sv
// Back end: clears the key store after reset, then probes it linearly per key.
// Depends on hsi_pkg and hsi_out_if; the key store memory lives here.
module hsi_back #(
  parameter int TABLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  logic [TABLE_BITS+hsi_pkg::KEY_W:0] q_data,
  output logic                               q_pop,
  output logic                               clearing,
  hsi_out_if.source                          out_ch
);

  localparam int TABLE_SIZE = 1 << TABLE_BITS;
  localparam int KW         = hsi_pkg::KEY_W;
  localparam int SW         = hsi_pkg::SLOT_W;

  hsi_pkg::back_state_t state_r, state_nxt;

  logic [KW-1:0]         mem [TABLE_SIZE];
  logic [KW-1:0]         rdata_r;
  logic [TABLE_BITS-1:0] rd_addr;
  logic                  wr_en;
  logic [TABLE_BITS-1:0] wr_addr;
  logic [KW-1:0]         wr_data;

  logic [TABLE_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic [TABLE_BITS-1:0] pos_r, pos_nxt;
  logic [TABLE_BITS-1:0] cnt_r, cnt_nxt;
  logic [KW-1:0]         key_r, key_nxt;

  logic                  out_valid_r, out_valid_nxt;
  hsi_pkg::status_t      status_r, status_nxt;
  logic [SW-1:0]         slot_r, slot_nxt;
  logic                  out_free;
  logic                  load;

  logic [KW-1:0]         q_key;
  logic [TABLE_BITS-1:0] q_home;
  logic                  q_rsv;
  logic [TABLE_BITS+SW-1:0] pos_ext;

  assign q_key  = q_data[KW-1:0];
  assign q_home = q_data[KW+TABLE_BITS-1:KW];
  assign q_rsv  = q_data[KW+TABLE_BITS];

  // Slot field carries the low bits of the index, zero-extended if narrower
  assign pos_ext = {{SW{1'b0}}, pos_r};

  assign out_free = !out_valid_r || out_ch.ready;
  assign clearing = (state_r == hsi_pkg::BK_CLEAR);

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = status_r;
  assign out_ch.slot   = slot_r;

  // Next state, probe control and result load
  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    pos_nxt       = pos_r;
    cnt_nxt       = cnt_r;
    key_nxt       = key_r;
    rd_addr       = pos_r;
    wr_en         = 1'b0;
    wr_addr       = pos_r;
    wr_data       = key_r;
    q_pop         = 1'b0;
    load          = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    status_nxt    = status_r;
    slot_nxt      = slot_r;
    unique case (state_r)
      hsi_pkg::BK_CLEAR: begin
        wr_en        = 1'b1;
        wr_addr      = clr_addr_r;
        wr_data      = hsi_pkg::EMPTY_KEY;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          state_nxt = hsi_pkg::BK_IDLE;
        end
      end
      hsi_pkg::BK_IDLE: begin
        // Pop only when the result register will be free
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_rsv) begin
            load       = 1'b1;
            status_nxt = hsi_pkg::ST_FULL;
            slot_nxt   = '0;
          end else begin
            pos_nxt   = q_home;
            rd_addr   = q_home;
            cnt_nxt   = '0;
            key_nxt   = q_key;
            state_nxt = hsi_pkg::BK_PROBE;
          end
        end
      end
      hsi_pkg::BK_PROBE: begin
        if (rdata_r == key_r) begin
          load       = 1'b1;
          status_nxt = hsi_pkg::ST_PRESENT;
          slot_nxt   = pos_ext[SW-1:0];
          state_nxt  = hsi_pkg::BK_IDLE;
        end else if (rdata_r == hsi_pkg::EMPTY_KEY) begin
          wr_en      = 1'b1;
          load       = 1'b1;
          status_nxt = hsi_pkg::ST_INSERTED;
          slot_nxt   = pos_ext[SW-1:0];
          state_nxt  = hsi_pkg::BK_IDLE;
        end else if (&cnt_r) begin
          // Every slot visited without a match or a hole
          load       = 1'b1;
          status_nxt = hsi_pkg::ST_FULL;
          slot_nxt   = '0;
          state_nxt  = hsi_pkg::BK_IDLE;
        end else begin
          pos_nxt = pos_r + 1'b1;
          rd_addr = pos_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = hsi_pkg::BK_IDLE;
      end
    endcase
    if (load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hsi_pkg::BK_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    cnt_r    <= cnt_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
  end

  // Key store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  a_no_result_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    load && out_valid_r |-> out_ch.ready) else $error("result overwritten before taken");
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hsi_pkg::BK_CLEAR |-> !q_pop) else $error("queue popped during clear");
  a_insert_into_hole: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && state_r == hsi_pkg::BK_PROBE |-> rdata_r == hsi_pkg::EMPTY_KEY)
    else $error("insert over occupied slot");
  a_pop_progress: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> state_r == hsi_pkg::BK_PROBE || out_valid_r)
    else $error("popped key neither probed nor answered");

endmodule

>>> src/hash_set_insert_core.sv
// Top level of the insert-only linear-probing hash set of 64-bit keys.
// Depends on hsi_pkg, hsi_if, hsi_front, hsi_queue and hsi_back.
//
//   channel  dir  handshake     payload
//   in_ch    in   valid/ready   key[63:0]
//   out_ch   out  valid/ready   status[1:0], slot[9:0]
//
// After reset the key store is swept to empty, all 2**TABLE_BITS slots, with
// in_ch.ready low. A key then passes the hash stage and the queue into the
// probe engine; the single read port of the key store visits one slot per
// cycle. The reserved all-ones key is answered without a probe. A stalled
// out_ch holds the engine; the hash stage and queue keep taking keys until
// they fill.
module hash_set_insert_core #(
  parameter int TABLE_BITS = 10
) (
  input  logic      clk,
  input  logic      rst_n,
  hsi_in_if.sink    in_ch,
  hsi_out_if.source out_ch
);

  localparam int EW = TABLE_BITS + hsi_pkg::KEY_W + 1;

  logic          clearing;
  logic          q_push;
  logic          q_ready;
  logic [EW-1:0] q_in_data;
  logic          q_pop;
  logic          q_valid;
  logic [EW-1:0] q_out_data;

  hsi_front #(.TABLE_BITS(TABLE_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .clearing (clearing),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .q_data   (q_in_data)
  );

  hsi_queue #(.WIDTH(EW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in_data),
    .push_ok   (q_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_out_data)
  );

  hsi_back #(.TABLE_BITS(TABLE_BITS)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_out_data),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_ch   (out_ch)
  );

endmodule
